// ===== sv/mlpbc_pkg.sv =====
// shared types, codes and constants of the led pwm blink controller
// used by the controller, the datapath and the top level
`default_nettype none

package mlpbc_pkg;

  localparam logic [6:0]  DUTY_FULL    = 7'd100;
  localparam logic [15:0] TICK_UNITS   = 16'd3125;
  localparam logic [31:0] PERIOD_RESET = 32'd20000;
  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for any 32 bit x
  localparam logic [31:0] RECIP_100    = 32'h51EB851F;
  localparam int unsigned RECIP_SHIFT  = 37;
  localparam int unsigned STEP_W       = 26;

  typedef enum logic [2:0] {
    ACT_TOGGLE = 3'd0,
    ACT_SET    = 3'd1,
    ACT_DUTY   = 3'd2,
    ACT_BLINK  = 3'd3,
    ACT_TICK   = 3'd4
  } action_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic mul;
    logic load_out;
  } mlpbc_cmd_t;

  typedef struct packed {
    logic unknown;
    logic err;
    logic no_hit;
    logic more;
  } mlpbc_sts_t;

  // half period in 10 us units for a blink rate of 1 to 16 hz
  function automatic logic [15:0] blink_span_for(input logic [4:0] hz);
    logic [15:0] hp;
    case (hz)
      5'd1:    hp = 16'd50000;
      5'd2:    hp = 16'd25000;
      5'd3:    hp = 16'd16666;
      5'd4:    hp = 16'd12500;
      5'd5:    hp = 16'd10000;
      5'd6:    hp = 16'd8333;
      5'd7:    hp = 16'd7142;
      5'd8:    hp = 16'd6250;
      5'd9:    hp = 16'd5555;
      5'd10:   hp = 16'd5000;
      5'd11:   hp = 16'd4545;
      5'd12:   hp = 16'd4166;
      5'd13:   hp = 16'd3846;
      5'd14:   hp = 16'd3571;
      5'd15:   hp = 16'd3333;
      5'd16:   hp = 16'd3125;
      default: hp = 16'd0;
    endcase
    return hp;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mlpbc_ctrl.sv =====
// controller state machine of the led pwm blink controller
// depends on mlpbc_pkg for the command and status structs
`default_nettype none

module mlpbc_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire mlpbc_pkg::mlpbc_sts_t sts,
  output mlpbc_pkg::mlpbc_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_MUL  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.unknown || sts.no_hit) begin
          state_next = S_IDLE;
        end else if (sts.err) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = sts.more ? S_MUL : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mlpbc_datapath.sv =====
// datapath of the led pwm blink controller: led state, pulse math, result register
// depends on mlpbc_pkg for constants, codes and the half period table
`default_nettype none

module mlpbc_datapath #(
  parameter int LED_COUNT    = 4,
  parameter int MAX_BLINK_HZ = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  input  wire logic [31:0]           cfg_data,
  input  wire logic [2:0]            action,
  input  wire logic [2:0]            led_index,
  input  wire logic [7:0]            argument,
  input  wire mlpbc_pkg::mlpbc_cmd_t cmd,
  output mlpbc_pkg::mlpbc_sts_t      sts,
  output logic [2:0]                 channel,
  output logic [31:0]                pulse_width,
  output logic [6:0]                 duty_now,
  output logic                       status,
  output logic                       last_of_run
);

  localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  logic [31:0]                  period;
  logic [mlpbc_pkg::STEP_W-1:0] step;
  logic [2:0]                   act_q;
  logic [2:0]                   led_q;
  logic [7:0]                   arg_q;
  logic [6:0]                   duty_store [LED_COUNT];
  logic [LED_COUNT-1:0]         blink_mask;
  logic [15:0]                  span_store [LED_COUNT];
  logic [15:0]                  offset_store [LED_COUNT];
  logic [16:0]                  off_sum [LED_COUNT];
  logic [LED_COUNT-1:0]         hit;
  logic [LED_COUNT-1:0]         pending;
  logic [LED_COUNT-1:0]         sel_onehot;
  logic [LED_COUNT-1:0]         pending_left;
  logic [IDX_W-1:0]             sel;
  logic [IDX_W-1:0]             cur_idx;
  logic [31:0]                  prod;
  logic [6:0]                   duty_q;
  logic                         last_q;
  logic                         is_tick;
  logic                         unknown;
  logic                         led_bad;
  logic                         freq_bad;
  logic                         err;
  logic                         apply;

  assign is_tick  = (act_q == mlpbc_pkg::ACT_TICK);
  assign unknown  = (act_q > mlpbc_pkg::ACT_TICK);
  assign led_bad  = ({1'b0, led_q} >= 4'(LED_COUNT));
  assign freq_bad = (arg_q == 8'd0) || (arg_q > 8'(MAX_BLINK_HZ));
  assign err      = !is_tick && !unknown
                    && (led_bad || ((act_q == mlpbc_pkg::ACT_BLINK) && freq_bad));
  assign apply    = cmd.exec && !unknown && !err;

  always_comb begin
    for (int i = 0; i < LED_COUNT; i++) begin
      off_sum[i] = {1'b0, offset_store[i]} + {1'b0, mlpbc_pkg::TICK_UNITS};
      hit[i]     = blink_mask[i] && (off_sum[i] >= {1'b0, span_store[i]});
    end
  end

  // lowest pending led goes first
  always_comb begin
    sel = '0;
    for (int i = LED_COUNT - 1; i >= 0; i--) begin
      if (pending[i]) begin
        sel = IDX_W'(i);
      end
    end
    sel_onehot   = LED_COUNT'(1) << sel;
    pending_left = pending & ~sel_onehot;
  end

  assign sts.unknown = unknown;
  assign sts.err     = err;
  assign sts.no_hit  = is_tick && (hit == '0);
  assign sts.more    = (pending != '0);

  always_ff @(posedge clk) begin
    step <= mlpbc_pkg::STEP_W'((64'(period) * 64'(mlpbc_pkg::RECIP_100))
                              >> mlpbc_pkg::RECIP_SHIFT);
    if (cmd.capture) begin
      act_q <= action;
      led_q <= led_index;
      arg_q <= argument;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period     <= mlpbc_pkg::PERIOD_RESET;
      blink_mask <= '0;
      pending    <= '0;
      for (int i = 0; i < LED_COUNT; i++) begin
        duty_store[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        period <= cfg_data;
      end
      if (apply) begin
        pending <= is_tick ? hit : (LED_COUNT'(1) << led_q[IDX_W-1:0]);
      end else if (cmd.mul) begin
        pending <= pending_left;
      end
      for (int i = 0; i < LED_COUNT; i++) begin
        if (apply && is_tick) begin
          if (hit[i]) begin
            duty_store[i] <= (duty_store[i] == 7'd0) ? mlpbc_pkg::DUTY_FULL : 7'd0;
          end
        end else if (apply && (led_q == 3'(i))) begin
          case (act_q)
            mlpbc_pkg::ACT_TOGGLE: begin
              duty_store[i] <= (duty_store[i] == 7'd0) ? mlpbc_pkg::DUTY_FULL : 7'd0;
            end
            mlpbc_pkg::ACT_SET: begin
              blink_mask[i] <= 1'b0;
              duty_store[i] <= (arg_q != 8'd0) ? mlpbc_pkg::DUTY_FULL : 7'd0;
            end
            mlpbc_pkg::ACT_DUTY: begin
              blink_mask[i] <= 1'b0;
              duty_store[i] <= (arg_q > {1'b0, mlpbc_pkg::DUTY_FULL})
                               ? mlpbc_pkg::DUTY_FULL : arg_q[6:0];
            end
            mlpbc_pkg::ACT_BLINK: begin
              blink_mask[i] <= 1'b1;
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LED_COUNT; i++) begin
      if (apply && is_tick) begin
        if (blink_mask[i]) begin
          offset_store[i] <= hit[i] ? 16'd0 : off_sum[i][15:0];
        end
      end else if (apply && (led_q == 3'(i)) && (act_q == mlpbc_pkg::ACT_BLINK)) begin
        span_store[i]   <= mlpbc_pkg::blink_span_for(arg_q[4:0]);
        offset_store[i] <= 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      cur_idx <= sel;
      duty_q  <= duty_store[sel];
      prod    <= 32'(step) * 32'(mlpbc_pkg::DUTY_FULL - duty_store[sel]);
      last_q  <= (pending_left == '0);
    end
    if (cmd.load_out) begin
      channel     <= err ? led_q : 3'(cur_idx);
      pulse_width <= err ? 32'd0 : prod;
      duty_now    <= err ? 7'd0 : duty_q;
      status      <= err;
      last_of_run <= err || last_q;
    end
  end

endmodule

`default_nettype wire

// ===== sv/multi_led_pwm_blink_controller_core.sv =====
// sequence: a led command is captured, executed, multiplied and emitted; an invalid index or
// rate skips the multiply; a tick multiplies and emits once per toggled led, an idle tick or
// unknown action gives no result; each result also waits while the output register is held
// throughput: one request at a time; the next is taken once the last result is in the
// output register, pulse math is two registered multiplies (reciprocal of 100, duty)
// reset: synchronous; duty 0, no led blinking, period 20000, nothing pending
`default_nettype none

module multi_led_pwm_blink_controller_core #(
  parameter int LED_COUNT    = 4,
  parameter int MAX_BLINK_HZ = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  action,
  input  wire logic [2:0]  led_index,
  input  wire logic [7:0]  argument,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       channel,
  output logic [31:0]      pulse_width,
  output logic [6:0]       duty_now,
  output logic             status,
  output logic             last_of_run
);

  mlpbc_pkg::mlpbc_cmd_t cmd;
  mlpbc_pkg::mlpbc_sts_t sts;

  assign cfg_ready = 1'b1;

  mlpbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mlpbc_datapath #(
    .LED_COUNT    (LED_COUNT),
    .MAX_BLINK_HZ (MAX_BLINK_HZ)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .action      (action),
    .led_index   (led_index),
    .argument    (argument),
    .cmd         (cmd),
    .sts         (sts),
    .channel     (channel),
    .pulse_width (pulse_width),
    .duty_now    (duty_now),
    .status      (status),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

// ===== sv/mlpbc_checker.sv =====
// port level checks on the led pwm blink controller results
// bound to multi_led_pwm_blink_controller_core, no package needed
`default_nettype none

module mlpbc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  channel,
  input wire logic [31:0] pulse_width,
  input wire logic [6:0]  duty_now,
  input wire logic        status,
  input wire logic        last_of_run
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(channel) && $stable(pulse_width)
      && $stable(duty_now) && $stable(status) && $stable(last_of_run))
    else $error("stalled result changed");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> last_of_run)
    else $error("error result not last of run");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (pulse_width == 32'd0) && (duty_now == 7'd0))
    else $error("error result carries pulse or duty");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> duty_now <= 7'd100)
    else $error("duty above 100");

  a_full_on: assert property (@(posedge clk) disable iff (rst)
    out_valid && (duty_now == 7'd100) |-> pulse_width == 32'd0)
    else $error("full duty with nonzero pulse");

endmodule

bind multi_led_pwm_blink_controller_core mlpbc_checker u_mlpbc_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .channel     (channel),
  .pulse_width (pulse_width),
  .duty_now    (duty_now),
  .status      (status),
  .last_of_run (last_of_run)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the multi-led pwm blink controller core
// drives led commands and period writes, predicts every led update and checks it
// depends on mlpbc_pkg and multi_led_pwm_blink_controller_core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LED_TOTAL      = 4;
  localparam int          MAX_HZ         = 16;
  localparam int          HALF_SECOND    = 50000;
  localparam logic [2:0]  ACT_RSVD_FIRST = 3'd5;
  localparam logic [2:0]  ACT_RSVD_LAST  = 3'd7;
  localparam logic        STATUS_OK      = 1'b0;
  localparam logic        STATUS_INVALID = 1'b1;
  localparam int          IDLE_TAIL      = 8;
  localparam int          CYCLE_LIMIT    = 400000;

  typedef struct packed {
    logic [2:0]  channel;
    logic [31:0] pulse;
    logic [6:0]  duty;
    logic        status;
    logic        last;
  } led_update_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  action;
  logic [2:0]  led_index;
  logic [7:0]  argument;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  channel;
  logic [31:0] pulse_width;
  logic [6:0]  duty_now;
  logic        status;
  logic        last_of_run;

  // predictor state
  logic [31:0]          period_q = mlpbc_pkg::PERIOD_RESET;
  logic [6:0]           duty_pct [LED_TOTAL] = '{default: '0};
  logic [LED_TOTAL-1:0] blinking = '0;
  logic [15:0]          half_span [LED_TOTAL] = '{default: '0};
  logic [15:0]          phase_acc [LED_TOTAL] = '{default: '0};

  led_update_t expected_updates[$];
  led_update_t oldest;
  int          errors = 0;
  int          cycle_count = 0;
  bit          quiet_phase = 1'b0;

  multi_led_pwm_blink_controller_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .led_index  (led_index),
    .argument   (argument),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .channel    (channel),
    .pulse_width(pulse_width),
    .duty_now   (duty_now),
    .status     (status),
    .last_of_run(last_of_run)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t timeout with %0d updates pending", $time, expected_updates.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [31:0] pulse_for_duty(logic [6:0] duty);
    logic [63:0] step;
    step = 64'(period_q / 32'd100);
    return 32'(step * (64'd100 - 64'(duty)));
  endfunction

  function automatic void compute_led_updates(logic [2:0] act, logic [2:0] led,
                                              logic [7:0] arg);
    led_update_t upd;
    led_update_t batch[$];
    logic [16:0] advanced;
    int          idx;
    idx = led;
    upd = '{channel: led, pulse: '0, duty: '0, status: STATUS_INVALID, last: 1'b1};
    if (act == mlpbc_pkg::ACT_TICK) begin
      for (int i = 0; i < LED_TOTAL; i++) begin
        if (blinking[i]) begin
          advanced = {1'b0, phase_acc[i]} + {1'b0, mlpbc_pkg::TICK_UNITS};
          if (advanced >= {1'b0, half_span[i]}) begin
            phase_acc[i] = '0;
            duty_pct[i] = (duty_pct[i] == '0) ? mlpbc_pkg::DUTY_FULL : '0;
            batch.push_back('{channel: 3'(i), pulse: pulse_for_duty(duty_pct[i]),
                              duty: duty_pct[i], status: STATUS_OK, last: 1'b0});
          end else begin
            phase_acc[i] = advanced[15:0];
          end
        end
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[k]) expected_updates.push_back(batch[k]);
      return;
    end
    if (act >= ACT_RSVD_FIRST) return;
    if (idx >= LED_TOTAL) begin
      expected_updates.push_back(upd);
      return;
    end
    case (mlpbc_pkg::action_t'(act))
      mlpbc_pkg::ACT_TOGGLE: duty_pct[idx] = (duty_pct[idx] == '0) ? mlpbc_pkg::DUTY_FULL : '0;
      mlpbc_pkg::ACT_SET: begin
        blinking[idx] = 1'b0;
        duty_pct[idx] = (arg != '0) ? mlpbc_pkg::DUTY_FULL : '0;
      end
      mlpbc_pkg::ACT_DUTY: begin
        blinking[idx] = 1'b0;
        duty_pct[idx] = (arg > 8'(mlpbc_pkg::DUTY_FULL)) ? mlpbc_pkg::DUTY_FULL : arg[6:0];
      end
      default: begin
        if (arg == '0 || arg > 8'(MAX_HZ)) begin
          expected_updates.push_back(upd);
          return;
        end
        half_span[idx] = 16'(HALF_SECOND / int'(arg));
        phase_acc[idx] = '0;
        blinking[idx] = 1'b1;
      end
    endcase
    upd.pulse = pulse_for_duty(duty_pct[idx]);
    upd.duty = duty_pct[idx];
    upd.status = STATUS_OK;
    expected_updates.push_back(upd);
  endfunction

  task automatic check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, field, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_updates.size() == 0) begin
        $display("%0t unexpected update: expected none actual channel %0d", $time, channel);
        errors++;
      end else begin
        oldest = expected_updates.pop_front();
        check_field("channel", 32'(oldest.channel), 32'(channel));
        check_field("pulse_width", oldest.pulse, pulse_width);
        check_field("duty_now", 32'(oldest.duty), 32'(duty_now));
        check_field("status", 32'(oldest.status), 32'(status));
        check_field("last_of_run", 32'(oldest.last), 32'(last_of_run));
      end
    end
  end

  // receiver backpressure in bursts, always ready in the quiet phase
  initial begin
    int len;
    out_ready = 1'b0;
    forever begin
      if (quiet_phase) begin
        @(negedge clk);
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 16);
        repeat (len) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end else begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
        repeat (len) begin
          @(negedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  task automatic send_command(logic [2:0] act, logic [2:0] led, logic [7:0] arg);
    int gap;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    action <= act;
    led_index <= led;
    argument <= arg;
    do @(posedge clk); while (!in_ready);
    compute_led_updates(act, led, arg);
  endtask

  task automatic wait_until_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic write_period(logic [31:0] value);
    wait_until_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    period_q = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] blink_rate();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(1, MAX_HZ));
    if ($urandom_range(0, 1) == 0) return 8'd0;
    return 8'($urandom_range(MAX_HZ + 1, 255));
  endfunction

  function automatic void random_command(output logic [2:0] act, output logic [2:0] led,
                                         output logic [7:0] arg);
    int pick;
    pick = $urandom_range(0, 99);
    led = ($urandom_range(0, 99) < 88) ? 3'($urandom_range(0, LED_TOTAL - 1))
                                       : 3'($urandom_range(LED_TOTAL, 7));
    arg = 8'($urandom);
    if (pick < 15) begin
      act = mlpbc_pkg::ACT_TOGGLE;
    end else if (pick < 25) begin
      act = mlpbc_pkg::ACT_SET;
      if ($urandom_range(0, 2) == 0) arg = '0;
    end else if (pick < 40) begin
      act = mlpbc_pkg::ACT_DUTY;
      if ($urandom_range(0, 9) < 7) arg = 8'($urandom_range(0, 100));
    end else if (pick < 55) begin
      act = mlpbc_pkg::ACT_BLINK;
      arg = blink_rate();
    end else if (pick < 95) begin
      act = mlpbc_pkg::ACT_TICK;
      led = 3'($urandom);
    end else begin
      act = 3'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST));
    end
  endfunction

  task automatic test_directed_cases();
    send_command(mlpbc_pkg::ACT_TOGGLE, 3'd0, 8'd0);
    send_command(mlpbc_pkg::ACT_TOGGLE, 3'd0, 8'hFF);
    send_command(mlpbc_pkg::ACT_SET, 3'd1, 8'h80);
    send_command(mlpbc_pkg::ACT_SET, 3'd1, 8'd0);
    send_command(mlpbc_pkg::ACT_DUTY, 3'd2, 8'hFF);
    send_command(mlpbc_pkg::ACT_DUTY, 3'd2, 8'd100);
    send_command(mlpbc_pkg::ACT_DUTY, 3'd3, 8'd37);
    send_command(mlpbc_pkg::ACT_DUTY, 3'd3, 8'd0);
    send_command(mlpbc_pkg::ACT_TOGGLE, 3'd7, 8'd0);
    send_command(mlpbc_pkg::ACT_DUTY, 3'd4, 8'd50);
    send_command(mlpbc_pkg::ACT_BLINK, 3'd5, 8'd4);
    send_command(mlpbc_pkg::ACT_SET, 3'd6, 8'd1);
    send_command(mlpbc_pkg::ACT_BLINK, 3'd0, 8'd0);
    send_command(mlpbc_pkg::ACT_BLINK, 3'd0, 8'd17);
    send_command(mlpbc_pkg::ACT_BLINK, 3'd0, 8'hFF);
    send_command(mlpbc_pkg::ACT_BLINK, 3'd0, 8'd16);
    send_command(mlpbc_pkg::ACT_BLINK, 3'd1, 8'd1);
    send_command(mlpbc_pkg::ACT_TICK, 3'd0, 8'd0);
    send_command(mlpbc_pkg::ACT_TICK, 3'd7, 8'hFF);
    send_command(mlpbc_pkg::ACT_TOGGLE, 3'd0, 8'd0);
    send_command(ACT_RSVD_FIRST, 3'd0, 8'd0);
    send_command(ACT_RSVD_LAST, 3'd7, 8'hFF);
    send_command(mlpbc_pkg::ACT_SET, 3'd0, 8'd1);
    send_command(mlpbc_pkg::ACT_TICK, 3'd2, 8'd3);
  endtask

  task automatic test_period_extremes();
    logic [31:0] periods [6];
    periods = '{32'd0, 32'hFFFF_FFFF, 32'd99, 32'd100, 32'd101, 32'($urandom)};
    foreach (periods[p]) begin
      write_period(periods[p]);
      send_command(mlpbc_pkg::ACT_DUTY, 3'd0, 8'd0);
      send_command(mlpbc_pkg::ACT_DUTY, 3'd1, 8'd1);
      send_command(mlpbc_pkg::ACT_DUTY, 3'd2, 8'd55);
      send_command(mlpbc_pkg::ACT_DUTY, 3'd3, 8'd100);
      send_command(mlpbc_pkg::ACT_TOGGLE, 3'($urandom_range(0, LED_TOTAL - 1)),
                   8'($urandom));
    end
  endtask

  task automatic test_random_commands();
    logic [2:0] act;
    logic [2:0] led;
    logic [7:0] arg;
    repeat (3) begin
      write_period(($urandom_range(0, 1) == 0) ? 32'($urandom) : 32'($urandom_range(0, 100000)));
      repeat (70) begin
        random_command(act, led, arg);
        send_command(act, led, arg);
      end
    end
  endtask

  task automatic test_blink_sequences();
    int         blinkers;
    int         ticks;
    logic [2:0] act;
    logic [2:0] led;
    logic [7:0] arg;
    write_period(mlpbc_pkg::PERIOD_RESET);
    repeat (10) begin
      blinkers = $urandom_range(1, LED_TOTAL);
      repeat (blinkers) begin
        send_command(mlpbc_pkg::ACT_BLINK, 3'($urandom_range(0, LED_TOTAL - 1)),
                     blink_rate());
      end
      ticks = $urandom_range(6, 20);
      repeat (ticks) begin
        if ($urandom_range(0, 9) == 0) begin
          random_command(act, led, arg);
          send_command(act, led, arg);
        end else begin
          send_command(mlpbc_pkg::ACT_TICK, 3'($urandom), 8'($urandom));
        end
      end
    end
  endtask

  task automatic test_quiet_finish();
    logic [2:0] act;
    logic [2:0] led;
    logic [7:0] arg;
    quiet_phase = 1'b1;
    write_period(32'($urandom_range(100, 1000000)));
    repeat (60) begin
      random_command(act, led, arg);
      send_command(act, led, arg);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    action = '0;
    led_index = '0;
    argument = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_period_extremes();
    test_random_commands();
    test_blink_sequences();
    test_quiet_finish();
    wait_until_idle();
    if (expected_updates.size() != 0) begin
      $display("%0t %0d updates never arrived", $time, expected_updates.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mlpbc_pkg.sv
sv/mlpbc_ctrl.sv
sv/mlpbc_datapath.sv
sv/multi_led_pwm_blink_controller_core.sv
sv/mlpbc_checker.sv
tb/sv/testbench.sv
